FILE: src/single_float_add_sub_truncating_top_defines.svh
// assertion macros for the float add/sub block
// used by the top level; SYNTH removes the checks
`ifndef SINGLE_FLOAT_ADD_SUB_TRUNCATING_TOP_DEFINES_SVH
`define SINGLE_FLOAT_ADD_SUB_TRUNCATING_TOP_DEFINES_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m: check failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("%m: check failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: src/sfas_pkg.sv
// shared types and constants for the float add/sub pipeline
// no dependencies
package sfas_pkg;
  localparam int unsigned FracBits = 23;
  localparam int unsigned ExpBits = 8;
  localparam int unsigned ManBits = FracBits + 1;
  localparam int unsigned LzcBits = 5;
  localparam logic [ExpBits-1:0] ExpMax = 8'hFF;
  localparam int unsigned StagesDefault = 4;

  typedef logic [ExpBits-1:0] exp_t;
  typedef logic [ManBits:0] sum_t;

  // stage 1 to 2: aligned operands
  typedef struct packed {
    logic sa;
    logic sb;
    exp_t e;
    logic [ManBits-1:0] ma;
    logic [ManBits-1:0] mb;
  } align_t;

  // stage 2 to 3: raw magnitude
  typedef struct packed {
    logic sr;
    exp_t e;
    sum_t mr;
  } raw_t;

  // stage 3 to 4: leading zero count ready
  typedef struct packed {
    logic sr;
    exp_t e;
    sum_t mr;
    logic [LzcBits-1:0] lz;
  } norm_t;

  function automatic logic [LzcBits-1:0] lzc24(input logic [ManBits-1:0] m);
    logic [LzcBits-1:0] n;
    logic found;
    n = LzcBits'(ManBits);
    found = 1'b0;
    for (int i = ManBits - 1; i >= 0; i--) begin
      if (!found && m[i]) begin
        n = LzcBits'(ManBits - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

FILE: src/sfas_datapath.sv
// four-stage add/sub datapath: align, add, count zeros, normalize and pack
// depends on sfas_pkg
module sfas_datapath (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] res
);
  sfas_pkg::align_t s1, s1_next;
  sfas_pkg::raw_t s2, s2_next;
  sfas_pkg::norm_t s3, s3_next;
  logic [31:0] s4_next;

  // align
  always_comb begin
    logic sa, sb;
    logic [7:0] ea, eb, d;
    logic [23:0] ma, mb;
    sa = a[31];
    sb = b[31] ^ sub;
    ea = a[30:23];
    eb = b[30:23];
    ma = {1'b1, a[22:0]};
    mb = {1'b1, b[22:0]};
    if (ea < eb) begin
      s1_next.sa = sb; s1_next.sb = sa; s1_next.e = eb; s1_next.ma = mb;
      d = eb - ea; s1_next.mb = (d >= 8'd24) ? '0 : (ma >> d);
    end else begin
      s1_next.sa = sa; s1_next.sb = sb; s1_next.e = ea; s1_next.ma = ma;
      d = ea - eb; s1_next.mb = (d >= 8'd24) ? '0 : (mb >> d);
    end
  end

  // add or magnitude subtract
  always_comb begin
    s2_next.e = s1.e;
    if (s1.sa != s1.sb) begin
      if (s1.ma >= s1.mb) begin
        s2_next.mr = {1'b0, s1.ma - s1.mb}; s2_next.sr = s1.sa;
      end else begin
        s2_next.mr = {1'b0, s1.mb - s1.ma}; s2_next.sr = ~s1.sa;
      end
    end else begin
      s2_next.mr = {1'b0, s1.ma} + {1'b0, s1.mb};
      s2_next.sr = s1.sa;
    end
  end

  always_comb begin
    s3_next.sr = s2.sr;
    s3_next.e = s2.e;
    s3_next.mr = s2.mr;
    s3_next.lz = sfas_pkg::lzc24(s2.mr[23:0]);
  end

  // normalize, saturate, flush, pack
  always_comb begin
    logic signed [9:0] e;
    logic [24:0] m;
    if (s3.mr[24]) begin
      m = s3.mr >> 1;
      e = $signed({2'b00, s3.e}) + 10'sd1;
    end else begin
      m = s3.mr << s3.lz;
      e = $signed({2'b00, s3.e}) - $signed({5'b0, s3.lz});
    end
    if (s3.mr == '0) s4_next = {s3.sr, 31'b0};
    else if (e >= 10'sd255) s4_next = {s3.sr, sfas_pkg::ExpMax, 23'b0};
    else if (e <= 10'sd0) s4_next = {s3.sr, 31'b0};
    else s4_next = {s3.sr, e[7:0], m[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      res <= s4_next;
    end
  end

  logic unused_rst;
  assign unused_rst = rst;
endmodule

FILE: src/single_float_add_sub_truncating_top.sv
// top level of the truncating binary32 adder/subtractor
// depends on sfas_pkg, sfas_datapath and the defines header
//
// channel | dir | fields
// s_axis  | in  | tdata[31:0] operand_a, [63:32] operand_b, [64] op
// m_axis  | out | tdata[31:0] sum_bits
//
// one word enters per cycle while m_axis is not stalled; words pass through the
// align, add, zero count and normalize stages
// a stall at m_axis freezes the whole pipeline together with its valid bits
// rst clears only the valid bits
`include "single_float_add_sub_truncating_top_defines.svh"
module single_float_add_sub_truncating_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // operand_a, operand_b, op, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // sum_bits
);
  // stage count is fixed by the datapath
  localparam int unsigned Stages = sfas_pkg::StagesDefault;

  logic [Stages-1:0] vld;
  logic en;

  // pipeline moves when the last stage is empty or being taken
  assign en = m_axis_tready || !vld[Stages-1];
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-2:0], s_axis_tvalid};
    end
  end

  sfas_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .en(en),
    .a(s_axis_tdata[31:0]),
    .b(s_axis_tdata[63:32]),
    .sub(s_axis_tdata[64]),
    .res(m_axis_tdata)
  );

  logic [6:0] unused_pad;
  assign unused_pad = s_axis_tdata[71:65];

  `ASSERT_CLK(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `ASSERT_CLK(a_ready, clk, rst, !m_axis_tvalid |-> s_axis_tready)
  `ASSERT_NORST(a_rst, clk, $past(rst) |-> !m_axis_tvalid)
endmodule

FILE: test/tb_single_float_add_sub_truncating_top.sv
// testbench for the truncating binary32 adder/subtractor
// depends on single_float_add_sub_truncating_top and sfas_pkg
// drives operand words, predicts each sum and checks the output stream in order
module tb_single_float_add_sub_truncating_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OpAdd = 1'b0;
  localparam logic OpSub = 1'b1;
  localparam int unsigned CycleLimit = 400000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        op;
  } fop_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // operand_a, operand_b, op, zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // sum_bits

  fop_t        pending_ops[$];
  logic [31:0] expected_sums[$];
  int          errors = 0;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_go = 1'b0;
  int          hold_count = 0;
  logic        in_taken = 1'b0;

  single_float_add_sub_truncating_top dut (.*);

  // truncating add/sub with implicit one on every exponent, no inf/nan handling
  function automatic logic [31:0] trunc_add_sub(input fop_t w);
    logic        sa, sb, sr, ts;
    int          ea, eb, e, te, d;
    logic [24:0] ma, mb, mr, tm;
    sa = w.a[31];
    sb = w.b[31] ^ (w.op == OpSub);
    ea = int'(w.a[30:23]);
    eb = int'(w.b[30:23]);
    ma = {2'b01, w.a[22:0]};
    mb = {2'b01, w.b[22:0]};
    // larger exponent goes first, ties keep a first
    if (ea < eb) begin
      ts = sa; sa = sb; sb = ts;
      tm = ma; ma = mb; mb = tm;
      te = ea; ea = eb; eb = te;
    end
    d = ea - eb;
    mb = (d >= 24) ? 25'd0 : (mb >> d);
    e = ea;
    if (sa != sb) begin
      if (ma >= mb) begin
        mr = ma - mb; sr = sa;
      end else begin
        mr = mb - ma; sr = ~sa;
      end
    end else begin
      mr = ma + mb; sr = sa;
    end
    if (mr == 0) return {sr, 31'd0};
    if (mr[24]) begin
      mr = mr >> 1; e++;
    end else begin
      while (!mr[23]) begin
        mr = mr << 1; e--;
      end
    end
    if (e >= 255) return {sr, 8'hFF, 23'd0};
    if (e <= 0) return {sr, 31'd0};
    return {sr, 8'(e), mr[22:0]};
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'hFE;
      3: v[30:23] = 8'h01;
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_op(input logic [31:0] a, input logic [31:0] b, input logic op);
    fop_t w;
    w.a = a; w.b = b; w.op = op;
    pending_ops.push_back(w);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset held at the start, once
  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  // directed words, then random words in three idling phases
  initial begin
    logic [31:0] r, s;
    int          kind;
    send_idle_pct = 9;
    recv_idle_pct = 52;
    // zeros, extremes, equal magnitudes, overflow and underflow
    queue_op(32'h0000_0000, 32'h0000_0000, OpAdd);
    queue_op(32'h3F80_0000, 32'h3F80_0000, OpSub);
    queue_op(32'hBF80_0000, 32'h3F80_0000, OpAdd);
    queue_op(32'h7F7F_FFFF, 32'h7F7F_FFFF, OpAdd);
    queue_op(32'hFFFF_FFFF, 32'h7FFF_FFFF, OpSub);
    queue_op(32'hFFFF_FFFF, 32'hFFFF_FFFF, OpAdd);
    queue_op(32'h0080_0000, 32'h0080_0001, OpSub);
    queue_op(32'h0000_0001, 32'h0000_0000, OpSub);
    queue_op(32'h3F80_0000, 32'h3380_0000, OpAdd);
    queue_op(32'h3F80_0000, 32'h3300_0000, OpSub);
    queue_op(32'h3F80_0000, 32'h4B80_0000, OpSub);
    queue_op(32'h3FC0_0000, 32'h4000_0000, OpSub);
    queue_op(32'h4000_0000, 32'h3FFF_FFFF, OpSub);
    queue_op(32'h7F00_0000, 32'hFF00_0000, OpSub);
    queue_op(32'h3F7F_FFFF, 32'h3F80_0000, OpSub);
    queue_op(32'hC040_0000, 32'h4040_0000, OpSub);
    queue_op(32'h0100_0000, 32'h8080_0000, OpAdd);
    queue_op(32'h5555_5555, 32'hAAAA_AAAA, OpAdd);
    queue_op(32'hAAAA_AAAA, 32'h5555_5555, OpSub);
    for (int i = 0; i < 1350; i++) begin
      if (i == 450) begin
        wait (pending_ops.size() == 0);
        send_idle_pct = 52;
        recv_idle_pct = 9;
      end
      if (i == 900) begin
        wait (pending_ops.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
      end
      r = rand_float();
      kind = $urandom_range(0, 3);
      // near exponents make cancellation and short shifts common
      if (kind < 2) begin
        s = rand_float();
        s[30:23] = r[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
        if (kind == 0) s[31] = r[31];
      end else begin
        s = rand_float();
      end
      queue_op(r, s, 1'($urandom));
    end
  end

  // driver, changes at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || in_taken) begin
      // previous word taken or none offered
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pending_ops[0].op, pending_ops[0].b, pending_ops[0].a};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness, with one long hold to fill the pipe
  always @(negedge clk) begin
    if (hold_go && hold_count < HoldCycles) begin
      m_axis_tready <= 1'b0;
      hold_count    <= hold_count + 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor, sampled at the rising edge
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        expected_sums.push_back(trunc_add_sub(pending_ops[0]));
        void'(pending_ops.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) begin
          $error("sum_bits: unexpected word %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (m_axis_tdata !== want) begin
            $error("sum_bits: expected %h actual %h", want, m_axis_tdata);
            errors++;
          end
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    cycles = 0;
    fork
      begin
        @(negedge rst);
        wait (pending_ops.size() == 0 && expected_sums.size() == 0
              && !s_axis_tvalid);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_sums.size() == 0) begin
          $display("[single_float_add_sub_truncating_top] OK");
        end else begin
          $display("[single_float_add_sub_truncating_top] ERROR");
        end
        $finish;
      end
      begin
        while (cycles < CycleLimit) begin
          @(posedge clk);
          cycles++;
        end
        $display("[single_float_add_sub_truncating_top] ERROR");
        $finish;
      end
    join
  end
endmodule
